// File: design/gtsp_pkg.sv
// gtsp_pkg: shared constants, command and status codes, and control structs
// for the generation-tagged slot pool
// no dependencies
`default_nettype none

package gtsp_pkg;

    // default pool size
    localparam int unsigned SLOTS_DEFAULT = 64;

    // field widths
    localparam int unsigned GEN_W       = 32;
    localparam int unsigned HANDLE_W    = 64;
    localparam int unsigned CMD_W       = 2;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned SLOT_OUT_W  = 6;
    localparam int unsigned COUNT_OUT_W = 7;

    // stream widths
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 80;
    localparam int unsigned M_TUSER_W = 2;

    // occupancy map is searched one chunk per cycle
    localparam int unsigned CHUNK   = 8;
    localparam int unsigned CHUNK_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    // occupancy map update controls
    typedef struct packed {
        logic set_bit;
        logic clr_bit;
    } map_ctl_t;

    // result of one chunk search
    typedef struct packed {
        logic               found;
        logic [CHUNK_W-1:0] pos;
    } scan_res_t;

endpackage

`default_nettype wire

// File: design/gtsp_tag_ram.sv
// gtsp_tag_ram: generation tag memory, one write and one registered read port
// depends on nothing; contents are only meaningful where the occupancy map is set
`default_nettype none

module gtsp_tag_ram #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned DATA_W = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] tag_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= tag_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/gtsp_free_map.sv
// gtsp_free_map: per-slot occupancy bits and the shared chunk search unit
// that finds the lowest free slot in one chunk of the map
// depends on gtsp_pkg
`default_nettype none

module gtsp_free_map #(
    parameter int unsigned SLOTS = gtsp_pkg::SLOTS_DEFAULT,
    parameter int unsigned NCW   = 3
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire gtsp_pkg::map_ctl_t       ctl,
    input  wire logic [$clog2(SLOTS)-1:0] addr,
    input  wire logic [NCW-1:0]           chunk_sel,
    output logic                          occ_bit,
    output gtsp_pkg::scan_res_t           scan
);

    import gtsp_pkg::*;

    localparam int unsigned NCHUNK = (SLOTS + CHUNK - 1) / CHUNK;
    localparam int unsigned PADW   = NCHUNK * CHUNK;

    logic [SLOTS-1:0] occ_reg;
    logic [SLOTS-1:0] occ_next;
    logic [PADW-1:0]  occ_pad;
    logic [CHUNK-1:0] word;

    // padding past the pool reads as occupied so it is never chosen
    always_comb begin
        occ_pad             = '1;
        occ_pad[SLOTS-1:0]  = occ_reg;
        word                = occ_pad[chunk_sel*CHUNK +: CHUNK];
    end

    // lowest clear bit of the selected chunk
    always_comb begin
        scan.found = 1'b0;
        scan.pos   = '0;
        for (int i = CHUNK - 1; i >= 0; i--) begin
            if (!word[i]) begin
                scan.found = 1'b1;
                scan.pos   = CHUNK_W'(i);
            end
        end
    end

    assign occ_bit = occ_reg[addr];

    // set on allocate, clear on free
    always_comb begin
        occ_next = occ_reg;
        if (ctl.set_bit) begin
            occ_next[addr] = 1'b1;
        end
        if (ctl.clr_bit) begin
            occ_next[addr] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

endmodule

`default_nettype wire

// File: design/generation_tagged_slot_pool.sv
// generation_tagged_slot_pool: top level, stream handshakes and the sequencer
// depends on gtsp_pkg, gtsp_tag_ram and gtsp_free_map

// A pool of SLOTS slots handing out 64-bit handles (generation << 32 | slot).
// Allocate takes the lowest free slot and tags it with a running generation
// that wraps from all ones to one; free and look-up accept a handle only if the
// slot is in range and in use and its tag equals the handle's nonzero
// generation. One item is worked on at a time. A look-up or free goes from
// acceptance through a tag memory read, a compare and an output load, a stale
// generation included; a handle with its slot out of range or a zero
// generation, an unused command or a full pool goes straight to the output
// load. An allocate steps the search unit through the 8-slot chunks of the
// occupancy map until it reaches the first free slot (1 to ceil(SLOTS/8)
// chunks). The result sits in an output register, so the next item is taken
// while it waits on m_tready. No clearing pass is needed after reset.
`default_nettype none

module generation_tagged_slot_pool #(
    parameter int unsigned SLOTS = gtsp_pkg::SLOTS_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // handle_id [63:0]
    input  wire logic [gtsp_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd [1:0]
    input  wire logic [gtsp_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // result_handle [63:0], slot_index [69:64], in_use_count [76:70], zero [79:77]
    output logic      [gtsp_pkg::M_TDATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic      [gtsp_pkg::M_TUSER_W-1:0]  m_tuser
);

    import gtsp_pkg::*;

    localparam int unsigned IDXW   = $clog2(SLOTS);
    localparam int unsigned CNTW   = $clog2(SLOTS + 1);
    localparam int unsigned NCHUNK = (SLOTS + CHUNK - 1) / CHUNK;
    localparam int unsigned NCW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int unsigned PADOUT = M_TDATA_W - HANDLE_W - SLOT_OUT_W - COUNT_OUT_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_CHECK  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]           state_reg,  state_next;
    logic [CMD_W-1:0]     cmd_reg,    cmd_next;
    logic [GEN_W-1:0]     gen_in_reg, gen_in_next;
    logic [IDXW-1:0]      idx_reg,    idx_next;
    logic [NCW-1:0]       chunk_reg,  chunk_next;
    logic [CNTW-1:0]      count_reg,  count_next;
    logic [GEN_W-1:0]     gen_ctr_reg, gen_ctr_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [HANDLE_W-1:0]  res_handle_reg, res_handle_next;
    logic [IDXW-1:0]      res_slot_reg,   res_slot_next;
    logic                 m_tvalid_reg,   m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg,    m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg,    m_tuser_next;

    logic                 accept;
    logic                 idx_ok;
    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic [GEN_W-1:0]     ram_rd_data;
    map_ctl_t             map_ctl;
    logic [IDXW-1:0]      map_addr;
    logic                 occ_bit;
    scan_res_t            scan;
    logic [NCW+CHUNK_W-1:0] scan_slot_full;
    logic [IDXW-1:0]      scan_slot;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign idx_ok   = (s_tdata[31:0] < 32'(SLOTS));

    assign scan_slot_full = {chunk_reg, scan.pos};
    assign scan_slot      = scan_slot_full[IDXW-1:0];
    assign map_addr       = (state_reg == S_SCAN) ? scan_slot : idx_reg;

    // tag memory
    gtsp_tag_ram #(
        .DEPTH  (SLOTS),
        .DATA_W (GEN_W)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (scan_slot),
        .wr_data (gen_ctr_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (s_tdata[IDXW-1:0]),
        .rd_data (ram_rd_data)
    );

    // occupancy bits and free-slot search
    gtsp_free_map #(
        .SLOTS (SLOTS),
        .NCW   (NCW)
    ) u_free_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (map_ctl),
        .addr      (map_addr),
        .chunk_sel (chunk_reg),
        .occ_bit   (occ_bit),
        .scan      (scan)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        gen_in_next     = gen_in_reg;
        idx_next        = idx_reg;
        chunk_next      = chunk_reg;
        count_next      = count_reg;
        gen_ctr_next    = gen_ctr_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_slot_next   = res_slot_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        map_ctl         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next        = s_tuser;
                    gen_in_next     = s_tdata[63:32];
                    idx_next        = s_tdata[IDXW-1:0];
                    chunk_next      = '0;
                    res_handle_next = s_tdata[HANDLE_W-1:0];
                    unique case (s_tuser) inside
                        CMD_ALLOC: begin
                            if (count_reg == CNTW'(SLOTS)) begin
                                res_status_next = ST_FULL;
                                res_handle_next = '0;
                                res_slot_next   = '0;
                                state_next      = S_FINISH;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_FREE, CMD_LOOKUP: begin
                            if (idx_ok && (s_tdata[63:32] != '0)) begin
                                ram_rd_en  = 1'b1;
                                state_next = S_CHECK;
                            end else begin
                                res_status_next = ST_BAD;
                                res_handle_next = '0;
                                res_slot_next   = '0;
                                state_next      = S_FINISH;
                            end
                        end
                        default: begin
                            res_status_next = ST_BAD;
                            res_handle_next = '0;
                            res_slot_next   = '0;
                            state_next      = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan.found) begin
                    ram_wr_en       = 1'b1;
                    map_ctl.set_bit = 1'b1;
                    count_next      = count_reg + 1'b1;
                    gen_ctr_next    = (gen_ctr_reg == '1) ? GEN_W'(1) : gen_ctr_reg + 1'b1;
                    res_status_next = ST_OK;
                    res_handle_next = {gen_ctr_reg, 32'(scan_slot)};
                    res_slot_next   = scan_slot;
                    state_next      = S_FINISH;
                end else begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            S_CHECK: begin
                if (occ_bit && (ram_rd_data == gen_in_reg)) begin
                    res_status_next = ST_OK;
                    res_slot_next   = idx_reg;
                    if (cmd_reg == CMD_FREE) begin
                        map_ctl.clr_bit = 1'b1;
                        count_next      = count_reg - 1'b1;
                    end
                end else begin
                    res_status_next = ST_BAD;
                    res_handle_next = '0;
                    res_slot_next   = '0;
                end
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {{PADOUT{1'b0}}, COUNT_OUT_W'(count_reg),
                                     SLOT_OUT_W'(res_slot_reg), res_handle_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            gen_ctr_reg  <= GEN_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            gen_ctr_reg  <= gen_ctr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // item payload and results
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        gen_in_reg     <= gen_in_next;
        idx_reg        <= idx_next;
        chunk_reg      <= chunk_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_slot_reg   <= res_slot_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
